### design/kfn_pkg.sv
// shared types, constants and the micro-program of the keyframe decision block
`default_nettype none

package kfn_pkg;

  // default width of the keyframe id counter
  localparam int ID_WIDTH_DEFAULT = 16;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSLATION_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION_LIMIT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRACKED_PERCENT_LIM = 2'd2;

  // register reset values
  localparam logic [31:0] TRANSLATION_LIMIT_RESET = 32'd9830;
  localparam logic [15:0] ROTATION_LIMIT_RESET    = 16'd2458;
  localparam logic [6:0]  TRACKED_LIMIT_RESET     = 7'd70;

  // operation codes
  localparam logic OPER_CHECK = 1'b0;
  localparam logic OPER_ADD   = 1'b1;

  // largest reported angle, 1/16384 rad
  localparam logic [23:0] ANGLE_MAX = 24'd51472;

  // operand sources of the shared multiplier
  typedef enum logic [4:0] {
    OP_QW, OP_QX, OP_QY, OP_QZ,
    OP_LW, OP_LX, OP_LY, OP_LZ,
    OP_RW, OP_RX, OP_RY, OP_RZ,
    OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8,
    OP_P0, OP_P1, OP_P2,
    OP_A0, OP_A1, OP_A2,
    OP_LIM, OP_LPT1, OP_PTS, OP_C100
  } opnd_t;

  // where a finished sum of products goes
  typedef enum logic [4:0] {
    D_NONE, D_W, D_X, D_Y, D_Z,
    D_R0, D_R1, D_R2, D_R3, D_R4, D_R5, D_R6, D_R7, D_R8,
    D_D0, D_D1, D_D2, D_SUM, D_VN, D_FEW
  } dest_t;

  // one multiply-accumulate term
  typedef struct packed {
    opnd_t a;
    opnd_t b;
    logic  neg;
    logic  dbl;
    logic  ini;
    logic  last;
    dest_t dest;
  } term_t;

  // one result item
  typedef struct packed {
    logic        need;
    logic        nokf;
    logic        moved;
    logic        turned;
    logic        few;
    logic [31:0] norm;
    logic [15:0] ang;
    logic [15:0] id;
  } res_t;

  localparam int TERM_IDX_W = 6;

  function automatic term_t mk(opnd_t a, opnd_t b, logic neg, logic dbl, logic ini,
                               logic last, dest_t d);
    term_t t;
    t.a = a;
    t.b = b;
    t.neg = neg;
    t.dbl = dbl;
    t.ini = ini;
    t.last = last;
    t.dest = d;
    return t;
  endfunction

  // micro-program: relative quaternion, rotation matrix, rotated translation,
  // squared norms and the tracked point test
  function automatic term_t term_at(logic [TERM_IDX_W-1:0] i);
    term_t t;
    case (i)
      6'd0:  t = mk(OP_QW, OP_LW, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd1:  t = mk(OP_QX, OP_LX, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd2:  t = mk(OP_QY, OP_LY, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd3:  t = mk(OP_QZ, OP_LZ, 1'b0, 1'b0, 1'b0, 1'b1, D_W);
      6'd4:  t = mk(OP_QW, OP_LX, 1'b1, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd5:  t = mk(OP_QX, OP_LW, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd6:  t = mk(OP_QY, OP_LZ, 1'b1, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd7:  t = mk(OP_QZ, OP_LY, 1'b0, 1'b0, 1'b0, 1'b1, D_X);
      6'd8:  t = mk(OP_QW, OP_LY, 1'b1, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd9:  t = mk(OP_QX, OP_LZ, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd10: t = mk(OP_QY, OP_LW, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd11: t = mk(OP_QZ, OP_LX, 1'b1, 1'b0, 1'b0, 1'b1, D_Y);
      6'd12: t = mk(OP_QW, OP_LZ, 1'b1, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd13: t = mk(OP_QX, OP_LY, 1'b1, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd14: t = mk(OP_QY, OP_LX, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd15: t = mk(OP_QZ, OP_LW, 1'b0, 1'b0, 1'b0, 1'b1, D_Z);
      6'd16: t = mk(OP_RY, OP_RY, 1'b1, 1'b1, 1'b1, 1'b0, D_NONE);
      6'd17: t = mk(OP_RZ, OP_RZ, 1'b1, 1'b1, 1'b0, 1'b1, D_R0);
      6'd18: t = mk(OP_RX, OP_RY, 1'b0, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd19: t = mk(OP_RW, OP_RZ, 1'b1, 1'b1, 1'b0, 1'b1, D_R1);
      6'd20: t = mk(OP_RX, OP_RZ, 1'b0, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd21: t = mk(OP_RW, OP_RY, 1'b0, 1'b1, 1'b0, 1'b1, D_R2);
      6'd22: t = mk(OP_RX, OP_RY, 1'b0, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd23: t = mk(OP_RW, OP_RZ, 1'b0, 1'b1, 1'b0, 1'b1, D_R3);
      6'd24: t = mk(OP_RX, OP_RX, 1'b1, 1'b1, 1'b1, 1'b0, D_NONE);
      6'd25: t = mk(OP_RZ, OP_RZ, 1'b1, 1'b1, 1'b0, 1'b1, D_R4);
      6'd26: t = mk(OP_RY, OP_RZ, 1'b0, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd27: t = mk(OP_RW, OP_RX, 1'b1, 1'b1, 1'b0, 1'b1, D_R5);
      6'd28: t = mk(OP_RX, OP_RZ, 1'b0, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd29: t = mk(OP_RW, OP_RY, 1'b1, 1'b1, 1'b0, 1'b1, D_R6);
      6'd30: t = mk(OP_RY, OP_RZ, 1'b0, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd31: t = mk(OP_RW, OP_RX, 1'b0, 1'b1, 1'b0, 1'b1, D_R7);
      6'd32: t = mk(OP_RX, OP_RX, 1'b1, 1'b1, 1'b1, 1'b0, D_NONE);
      6'd33: t = mk(OP_RY, OP_RY, 1'b1, 1'b1, 1'b0, 1'b1, D_R8);
      6'd34: t = mk(OP_M0, OP_P0, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd35: t = mk(OP_M1, OP_P1, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd36: t = mk(OP_M2, OP_P2, 1'b0, 1'b0, 1'b0, 1'b1, D_D0);
      6'd37: t = mk(OP_M3, OP_P0, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd38: t = mk(OP_M4, OP_P1, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd39: t = mk(OP_M5, OP_P2, 1'b0, 1'b0, 1'b0, 1'b1, D_D1);
      6'd40: t = mk(OP_M6, OP_P0, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd41: t = mk(OP_M7, OP_P1, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd42: t = mk(OP_M8, OP_P2, 1'b0, 1'b0, 1'b0, 1'b1, D_D2);
      6'd43: t = mk(OP_A0, OP_A0, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd44: t = mk(OP_A1, OP_A1, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd45: t = mk(OP_A2, OP_A2, 1'b0, 1'b0, 1'b0, 1'b1, D_SUM);
      6'd46: t = mk(OP_RX, OP_RX, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd47: t = mk(OP_RY, OP_RY, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd48: t = mk(OP_RZ, OP_RZ, 1'b0, 1'b0, 1'b0, 1'b1, D_VN);
      6'd49: t = mk(OP_LIM, OP_LPT1, 1'b0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd50: t = mk(OP_PTS, OP_C100, 1'b1, 1'b0, 1'b0, 1'b1, D_FEW);
      default: t = mk(OP_PTS, OP_C100, 1'b1, 1'b0, 1'b0, 1'b1, D_FEW);
    endcase
    return t;
  endfunction

  // arctangent of 2^-i, scaled for the doubled angle before the final shift
  function automatic logic [23:0] atan_step(logic [3:0] i);
    logic [23:0] v;
    case (i)
      4'd0:  v = 24'd823550;
      4'd1:  v = 24'd486170;
      4'd2:  v = 24'd256879;
      4'd3:  v = 24'd130396;
      4'd4:  v = 24'd65451;
      4'd5:  v = 24'd32757;
      4'd6:  v = 24'd16383;
      4'd7:  v = 24'd8192;
      4'd8:  v = 24'd4096;
      4'd9:  v = 24'd2048;
      4'd10: v = 24'd1024;
      4'd11: v = 24'd512;
      4'd12: v = 24'd256;
      4'd13: v = 24'd128;
      4'd14: v = 24'd64;
      default: v = 24'd32;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/kfn_if.sv
// handshake channels of the keyframe decision block
`default_nettype none

interface kfn_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        point_count;

  modport source (output valid, operation, quat_w, quat_x, quat_y, quat_z,
                  pos_x, pos_y, pos_z, point_count, input ready);
  modport sink (input valid, operation, quat_w, quat_x, quat_y, quat_z,
                pos_x, pos_y, pos_z, point_count, output ready);
endinterface

interface kfn_result_if;
  logic        valid;
  logic        ready;
  logic        need_keyframe;
  logic        no_keyframe_yet;
  logic        moved_too_far;
  logic        turned_too_far;
  logic        too_few_tracked;
  logic [31:0] translation_norm;
  logic [15:0] rotation_angle;
  logic [15:0] keyframe_id;

  modport source (output valid, need_keyframe, no_keyframe_yet, moved_too_far,
                  turned_too_far, too_few_tracked, translation_norm, rotation_angle,
                  keyframe_id, input ready);
  modport sink (input valid, need_keyframe, no_keyframe_yet, moved_too_far,
                turned_too_far, too_few_tracked, translation_norm, rotation_angle,
                keyframe_id, output ready);
endinterface

interface kfn_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [kfn_pkg::CFG_INDEX_W-1:0]    index;
  logic [31:0]                        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/kfn_isqrt.sv
// bit-serial integer square root of a 64-bit value, one result bit a cycle
`default_nettype none

module kfn_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  // candidate subtrahend for this bit
  assign trial = r + bitv;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        n <= value;
        r <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (n >= trial) begin
          n <= n - trial;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/keyframe_need_decision.sv
// keyframe decision: relative pose, translation norm, rotation angle, flags
`default_nettype none

// Takes one add or check item at a time. For an add, or for a check before
// any keyframe has been stored, the result goes straight to the output
// register. A full check runs 51 multiply-accumulate terms, each a multiply
// and an accumulate step, on one shared 33x33 multiplier, with a write-back
// after each sum of products, two square roots on the bit-serial root unit,
// 16 CORDIC steps on one shared shift-add unit, then a decision step and the
// load of the output register, which waits until that register is free. The
// input is ready only while the sequencer is idle, which it is again once the
// result is loaded; a finished result waits in the output register while the
// next item is taken.
module keyframe_need_decision #(
  parameter int ID_WIDTH = kfn_pkg::ID_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  kfn_item_if.sink      req,
  kfn_result_if.source  rsp,
  kfn_cfg_if.sink       cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_WB, S_SQN_GO, S_SQN_WAIT, S_SQV_GO, S_SQV_WAIT,
    S_CORDIC, S_DECIDE, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [31:0] tlim;
  logic [15:0] rlim;
  logic [6:0]  plim;

  // keyframe store
  logic                have_keyframe;
  logic [ID_WIDTH-1:0] nid;
  logic [31:0]         nid32;
  logic signed [15:0]  lw, lx, ly, lz;
  logic signed [31:0]  lpx, lpy, lpz;
  logic [15:0]         lpts;

  // current item
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] tx, ty, tz;
  logic [15:0]        pts;

  // intermediate values
  logic signed [15:0] rw, rx, ry, rz;
  logic signed [17:0] rm [9];
  logic [31:0]        ad [3];
  logic               big [3];
  logic signed [65:0] prod;
  logic signed [67:0] acc;
  logic               fresh;
  logic [kfn_pkg::TERM_IDX_W-1:0] tidx;
  logic [63:0]        sumsq;
  logic               satn;
  logic [63:0]        vsq;
  logic [31:0]        root_n;
  logic               few;
  logic signed [31:0] cx, cy;
  logic signed [23:0] cz;
  logic [3:0]         ci;

  // result staging and output register
  kfn_pkg::res_t pend;
  kfn_pkg::res_t obuf;
  logic          ovalid;

  // square root unit
  logic        sq_start;
  logic [63:0] sq_value;
  logic        sq_done;
  logic [31:0] sq_root;

  kfn_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign sq_start = (state == S_SQN_GO) || (state == S_SQV_GO);
  assign sq_value = (state == S_SQN_GO) ? sumsq : vsq;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign nid32 = 32'(nid);

  // output channel
  assign rsp.valid = ovalid;
  assign rsp.need_keyframe = obuf.need;
  assign rsp.no_keyframe_yet = obuf.nokf;
  assign rsp.moved_too_far = obuf.moved;
  assign rsp.turned_too_far = obuf.turned;
  assign rsp.too_few_tracked = obuf.few;
  assign rsp.translation_norm = obuf.norm;
  assign rsp.rotation_angle = obuf.ang;
  assign rsp.keyframe_id = obuf.id;

  // current term of the micro-program
  kfn_pkg::term_t term;
  assign term = kfn_pkg::term_at(tidx);

  // operand selection for the shared multiplier
  function automatic logic signed [32:0] opnd(kfn_pkg::opnd_t s);
    logic signed [32:0] v;
    case (s)
      kfn_pkg::OP_QW:   v = {{17{qw[15]}}, qw};
      kfn_pkg::OP_QX:   v = {{17{qx[15]}}, qx};
      kfn_pkg::OP_QY:   v = {{17{qy[15]}}, qy};
      kfn_pkg::OP_QZ:   v = {{17{qz[15]}}, qz};
      kfn_pkg::OP_LW:   v = {{17{lw[15]}}, lw};
      kfn_pkg::OP_LX:   v = {{17{lx[15]}}, lx};
      kfn_pkg::OP_LY:   v = {{17{ly[15]}}, ly};
      kfn_pkg::OP_LZ:   v = {{17{lz[15]}}, lz};
      kfn_pkg::OP_RW:   v = {{17{rw[15]}}, rw};
      kfn_pkg::OP_RX:   v = {{17{rx[15]}}, rx};
      kfn_pkg::OP_RY:   v = {{17{ry[15]}}, ry};
      kfn_pkg::OP_RZ:   v = {{17{rz[15]}}, rz};
      kfn_pkg::OP_M0:   v = {{15{rm[0][17]}}, rm[0]};
      kfn_pkg::OP_M1:   v = {{15{rm[1][17]}}, rm[1]};
      kfn_pkg::OP_M2:   v = {{15{rm[2][17]}}, rm[2]};
      kfn_pkg::OP_M3:   v = {{15{rm[3][17]}}, rm[3]};
      kfn_pkg::OP_M4:   v = {{15{rm[4][17]}}, rm[4]};
      kfn_pkg::OP_M5:   v = {{15{rm[5][17]}}, rm[5]};
      kfn_pkg::OP_M6:   v = {{15{rm[6][17]}}, rm[6]};
      kfn_pkg::OP_M7:   v = {{15{rm[7][17]}}, rm[7]};
      kfn_pkg::OP_M8:   v = {{15{rm[8][17]}}, rm[8]};
      kfn_pkg::OP_P0:   v = {lpx[31], lpx};
      kfn_pkg::OP_P1:   v = {lpy[31], lpy};
      kfn_pkg::OP_P2:   v = {lpz[31], lpz};
      kfn_pkg::OP_A0:   v = big[0] ? 33'sd0 : {1'b0, ad[0]};
      kfn_pkg::OP_A1:   v = big[1] ? 33'sd0 : {1'b0, ad[1]};
      kfn_pkg::OP_A2:   v = big[2] ? 33'sd0 : {1'b0, ad[2]};
      kfn_pkg::OP_LIM:  v = {26'd0, plim};
      kfn_pkg::OP_LPT1: v = {16'd0, ({1'b0, lpts} + 17'd1)};
      kfn_pkg::OP_PTS:  v = {17'd0, pts};
      kfn_pkg::OP_C100: v = 33'sd100;
      default:          v = 33'sd0;
    endcase
    return v;
  endfunction

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [67:0] pw, base, acc_next;

  assign mul_a = opnd(term.a);
  assign mul_b = opnd(term.b);
  assign mul_p = mul_a * mul_b;

  // accumulate the registered product, doubled and negated as the term asks
  always_comb begin
    pw = term.dbl ? {prod[65], prod, 1'b0} : {{2{prod[65]}}, prod};
    if (fresh) begin
      base = term.ini ? 68'sd268435456 : 68'sd0;
    end else begin
      base = acc;
    end
    acc_next = term.neg ? (base - pw) : (base + pw);
  end

  // write-back: round to Q.14, clamp, rotated translation difference
  logic signed [67:0] rn;
  logic signed [15:0] qclamp;
  logic signed [31:0] tsel;
  logic signed [67:0] dfull, dabs;
  logic               dbig;

  always_comb begin
    rn = (acc + 68'sd8192) >>> 14;
    if (rn > 68'sd16384) begin
      qclamp = 16'sd16384;
    end else if (rn < -68'sd16384) begin
      qclamp = -16'sd16384;
    end else begin
      qclamp = rn[15:0];
    end
    case (term.dest)
      kfn_pkg::D_D0: tsel = tx;
      kfn_pkg::D_D1: tsel = ty;
      default:       tsel = tz;
    endcase
    dfull = {{36{tsel[31]}}, tsel} - rn;
    dabs = dfull[67] ? -dfull : dfull;
    dbig = |dabs[67:32];
  end

  // shared shift-add unit for the CORDIC steps
  logic signed [31:0] xs, ys;
  logic [23:0]        at;
  logic [15:0]        wabs;

  assign xs = cx >>> ci;
  assign ys = cy >>> ci;
  assign at = kfn_pkg::atan_step(ci);
  assign wabs = rw[15] ? 16'(-rw) : rw;

  // final decision
  logic [23:0] zpos, zr;
  logic [15:0] angv;
  logic [31:0] normv;
  logic        moved, turned;

  always_comb begin
    zpos = cz[23] ? 24'd0 : cz;
    zr = (zpos + 24'd16) >> 5;
    angv = (zr > kfn_pkg::ANGLE_MAX) ? kfn_pkg::ANGLE_MAX[15:0] : zr[15:0];
    normv = satn ? 32'hFFFF_FFFF : root_n;
    moved = normv > tlim;
    turned = angv > rlim;
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      have_keyframe <= 1'b0;
      nid <= '0;
      ovalid <= 1'b0;
      tlim <= kfn_pkg::TRANSLATION_LIMIT_RESET;
      rlim <= kfn_pkg::ROTATION_LIMIT_RESET;
      plim <= kfn_pkg::TRACKED_LIMIT_RESET;
    end else begin
      // register writes
      if (cfg.valid) begin
        case (cfg.index)
          kfn_pkg::CFG_TRANSLATION_LIMIT:   tlim <= cfg.data;
          kfn_pkg::CFG_ROTATION_LIMIT:      rlim <= cfg.data[15:0];
          kfn_pkg::CFG_TRACKED_PERCENT_LIM: plim <= cfg.data[6:0];
          default: ;
        endcase
      end

      // output register valid: loaded from the staged result, cleared on transfer
      if ((state == S_DONE) && (!ovalid || rsp.ready)) begin
        ovalid <= 1'b1;
      end else if (ovalid && rsp.ready) begin
        ovalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            qw <= req.quat_w;
            qx <= req.quat_x;
            qy <= req.quat_y;
            qz <= req.quat_z;
            tx <= req.pos_x;
            ty <= req.pos_y;
            tz <= req.pos_z;
            pts <= req.point_count;
            if (req.operation == kfn_pkg::OPER_ADD) begin
              lw <= req.quat_w;
              lx <= req.quat_x;
              ly <= req.quat_y;
              lz <= req.quat_z;
              lpx <= req.pos_x;
              lpy <= req.pos_y;
              lpz <= req.pos_z;
              lpts <= req.point_count;
              have_keyframe <= 1'b1;
              pend <= {5'b0, 32'd0, 16'd0, nid32[15:0]};
              nid <= nid + ID_WIDTH'(1);
              state <= S_DONE;
            end else if (!have_keyframe) begin
              pend <= {1'b1, 1'b1, 3'b0, 32'd0, 16'd0, 16'd0};
              state <= S_DONE;
            end else begin
              tidx <= '0;
              fresh <= 1'b1;
              state <= S_MUL;
            end
          end
        end

        S_MUL: begin
          prod <= mul_p;
          state <= S_ACC;
        end

        S_ACC: begin
          acc <= acc_next;
          fresh <= term.last;
          if (term.last) begin
            state <= S_WB;
          end else begin
            tidx <= tidx + (kfn_pkg::TERM_IDX_W)'(1);
            state <= S_MUL;
          end
        end

        S_WB: begin
          tidx <= tidx + (kfn_pkg::TERM_IDX_W)'(1);
          state <= S_MUL;
          case (term.dest)
            kfn_pkg::D_W:  rw <= qclamp;
            kfn_pkg::D_X:  rx <= qclamp;
            kfn_pkg::D_Y:  ry <= qclamp;
            kfn_pkg::D_Z:  rz <= qclamp;
            kfn_pkg::D_R0: rm[0] <= rn[17:0];
            kfn_pkg::D_R1: rm[1] <= rn[17:0];
            kfn_pkg::D_R2: rm[2] <= rn[17:0];
            kfn_pkg::D_R3: rm[3] <= rn[17:0];
            kfn_pkg::D_R4: rm[4] <= rn[17:0];
            kfn_pkg::D_R5: rm[5] <= rn[17:0];
            kfn_pkg::D_R6: rm[6] <= rn[17:0];
            kfn_pkg::D_R7: rm[7] <= rn[17:0];
            kfn_pkg::D_R8: rm[8] <= rn[17:0];
            kfn_pkg::D_D0: begin
              ad[0] <= dabs[31:0];
              big[0] <= dbig;
            end
            kfn_pkg::D_D1: begin
              ad[1] <= dabs[31:0];
              big[1] <= dbig;
            end
            kfn_pkg::D_D2: begin
              ad[2] <= dabs[31:0];
              big[2] <= dbig;
            end
            kfn_pkg::D_SUM: begin
              sumsq <= acc[63:0];
              satn <= (|acc[67:64]) | big[0] | big[1] | big[2];
            end
            kfn_pkg::D_VN: vsq <= acc[63:0];
            kfn_pkg::D_FEW: begin
              few <= (acc > 68'sd0);
              state <= S_SQN_GO;
            end
            default: ;
          endcase
        end

        S_SQN_GO: state <= S_SQN_WAIT;

        S_SQN_WAIT: begin
          if (sq_done) begin
            root_n <= sq_root;
            state <= S_SQV_GO;
          end
        end

        S_SQV_GO: state <= S_SQV_WAIT;

        S_SQV_WAIT: begin
          if (sq_done) begin
            cx <= {8'd0, wabs, 8'd0};
            cy <= {8'd0, sq_root[15:0], 8'd0};
            cz <= '0;
            ci <= '0;
            state <= S_CORDIC;
          end
        end

        S_CORDIC: begin
          if (cy > 32'sd0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + $signed(at);
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - $signed(at);
          end
          ci <= ci + 4'd1;
          if (ci == 4'd15) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          pend <= {moved | turned | few, 1'b0, moved, turned, few, normv, angv, 16'd0};
          state <= S_DONE;
        end

        S_DONE: begin
          if (!ovalid || rsp.ready) begin
            obuf <= pend;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // an add always leaves a keyframe behind
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation == kfn_pkg::OPER_ADD) |=> have_keyframe)
    else $error("keyframe not stored after add");

  // ids advance by one per add, wrapping at the counter width
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation == kfn_pkg::OPER_ADD)
      |=> (nid == $past(nid) + ID_WIDTH'(1)))
    else $error("keyframe id did not advance");

  // the decision is the or of the individual reasons
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.need_keyframe == (rsp.no_keyframe_yet || rsp.moved_too_far ||
                   rsp.turned_too_far || rsp.too_few_tracked)))
    else $error("need flag disagrees with its reasons");

endmodule

`default_nettype wire
